### hw/rtl/lbs4_pkg.sv
// Shared constants and widths for the four-bone skinning block.
`default_nettype none

package lbs4_pkg;

	// Field and word widths.
	localparam int DATA_W  = 32;
	localparam int PROD_W  = 64;
	localparam int SUM_W   = 50;
	localparam int WP_W    = 59;
	localparam int ACC_W   = 62;
	localparam int DIV_W   = 64;
	localparam int DIV_BYTES = DIV_W / 8;

	// Palette organisation.
	localparam int DEFAULT_BONE_SLOTS = 256;
	localparam int WORDS_PER_BONE     = 12;
	localparam int ROWS_PER_BONE      = 3;
	localparam int PAL_COLS           = 4;
	localparam int BONES              = 4;

	// Rounding offset for the divide by 255.
	localparam int DIV_ROUND = 127;
	localparam int DIVISOR   = 255;

	// Request function codes.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_SKIN = 1'b1;

endpackage

`default_nettype wire

### hw/rtl/linear_blend_skinning_4bone.sv
// Top level of the four-bone linear blend skinning block: sequencer and shared multiplier.
`default_nettype none

// Four-bone linear blend skinning of one vertex in Q16.16 fixed point. Each
// request is either a palette load (func 0), which writes one matrix word at
// slot*12 + row*4 + column and produces no result, or a skin request (func 1),
// which produces exactly one result. A load leaves the block ready again at
// once. A skin request keeps the input stalled while each of the twelve bone
// rows passes through one palette row read, three products through the
// single shared 32x32 multiplier, the final row sum, the weight product and
// the accumulate, and each of the three coordinates then passes through a
// byte-serial divide by 255. A skin request whose base plus any bone index
// reaches BONE_SLOTS or more skips the arithmetic and returns zero
// coordinates with slot_error set. Products are floored to Q16.16 before the
// row sum, the weighted sum is divided by 255 with rounding to nearest and
// then saturated to the signed 32-bit range. Finished results sit in an output
// register, so the next request is taken while a result waits to be
// collected. Palette words that have never been loaded read back as arbitrary
// values.
module linear_blend_skinning_4bone
	import lbs4_pkg::*;
#(
	parameter int BONE_SLOTS = DEFAULT_BONE_SLOTS
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire                       func,
	input  wire  [11:0]               load_addr,
	input  wire  signed [DATA_W-1:0]  load_value,
	input  wire  signed [DATA_W-1:0]  pos_x,
	input  wire  signed [DATA_W-1:0]  pos_y,
	input  wire  signed [DATA_W-1:0]  pos_z,
	input  wire  [31:0]               bone_indices,
	input  wire  [31:0]               bone_weights,
	input  wire  [7:0]                palette_base,
	output logic                      out_valid,
	input  wire                       out_stall,
	output logic signed [DATA_W-1:0]  skin_x,
	output logic signed [DATA_W-1:0]  skin_y,
	output logic signed [DATA_W-1:0]  skin_z,
	output logic                      slot_error
);

	localparam int PAL_ROWS  = BONE_SLOTS * ROWS_PER_BONE;
	localparam int PAL_WORDS = BONE_SLOTS * WORDS_PER_BONE;
	localparam int RA        = $clog2(PAL_ROWS);

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FETCH  = 4'd1;
	localparam logic [3:0] S_MUL    = 4'd2;
	localparam logic [3:0] S_SUM    = 4'd3;
	localparam logic [3:0] S_WGT    = 4'd4;
	localparam logic [3:0] S_ACC    = 4'd5;
	localparam logic [3:0] S_DSTART = 4'd6;
	localparam logic [3:0] S_DWAIT  = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	// Operand step within one matrix row.
	localparam logic [1:0] STEP_X = 2'd0;
	localparam logic [1:0] STEP_Y = 2'd1;
	localparam logic [1:0] STEP_Z = 2'd2;

	logic [3:0] state_q;
	logic [1:0] bone_q;
	logic [1:0] row_q;
	logic [1:0] step_q;
	logic [1:0] coord_q;
	logic       err_q;

	// Latched request payload.
	logic signed [DATA_W-1:0] px_q, py_q, pz_q;
	logic [31:0] idx_q;
	logic [31:0] wts_q;
	logic [7:0]  base_q;

	// Datapath registers.
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [WP_W-1:0]   wprod_q;
	logic signed [ACC_W-1:0]  acc_q [3];
	logic [DATA_W-1:0]        res_q [3];
	logic                     neg_q;

	// Output register.
	logic                     out_valid_q;
	logic [DATA_W-1:0]        skin_x_q, skin_y_q, skin_z_q;
	logic                     slot_error_q;

	logic in_accept;
	logic load_req;
	logic load_ok;
	logic slot_bad;
	logic out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign load_req  = in_accept && (func == FUNC_LOAD);
	assign load_ok   = 32'(load_addr) < 32'(PAL_WORDS);
	assign out_free  = !out_valid_q || !out_stall;

	// A skin request is rejected if any base plus index lands past the palette.
	always_comb begin
		logic [8:0] slot;
		slot_bad = 1'b0;
		for (int b = 0; b < BONES; b++) begin
			slot = 9'(palette_base) + 9'(bone_indices[b*8 +: 8]);
			if (32'(slot) >= 32'(BONE_SLOTS)) begin
				slot_bad = 1'b1;
			end
		end
	end

	// Palette addressing. A load address splits into column (low two bits)
	// and row; a skin read fetches row slot*3 + row of the current bone.
	logic [RA+9:0]  wr_full;
	logic [RA-1:0]  wr_row;
	logic [8:0]     cur_slot;
	logic [RA+10:0] rd_full;
	logic [RA-1:0]  rd_row;
	logic [PAL_COLS-1:0][DATA_W-1:0] pal_row;

	assign wr_full  = (RA+10)'(load_addr[11:2]);
	assign wr_row   = wr_full[RA-1:0];
	assign cur_slot = 9'(base_q) + 9'(idx_q[{bone_q, 3'b000} +: 8]);
	assign rd_full  = (RA+11)'({cur_slot, 1'b0}) + (RA+11)'(cur_slot) + (RA+11)'(row_q);
	assign rd_row   = rd_full[RA-1:0];

	lbs4_palette #(
		.ROWS (PAL_ROWS)
	) u_palette (
		.clk     (clk),
		.wr_en   (load_req && load_ok),
		.wr_col  (load_addr[1:0]),
		.wr_row  (wr_row),
		.wr_data (load_value),
		.rd_en   (state_q == S_FETCH),
		.rd_row  (rd_row),
		.rd_data (pal_row)
	);

	// Shared multiplier operand selection: position coordinate against the
	// matching linear term of the current matrix row.
	logic signed [DATA_W-1:0] op_a;
	logic signed [DATA_W-1:0] op_b;
	logic signed [SUM_W-1:0]  prod_floor;
	logic [7:0]               cur_wt;

	always_comb begin
		case (step_q)
			STEP_X: begin
				op_a = px_q;
				op_b = $signed(pal_row[0]);
			end
			STEP_Y: begin
				op_a = py_q;
				op_b = $signed(pal_row[1]);
			end
			STEP_Z: begin
				op_a = pz_q;
				op_b = $signed(pal_row[2]);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Dropping the low sixteen bits of a two's complement product floors it.
	assign prod_floor = SUM_W'($signed(prod_q[PROD_W-1:16]));
	assign cur_wt     = wts_q[{bone_q, 3'b000} +: 8];

	// Divider interface: magnitude plus the rounding offset.
	logic [ACC_W-1:0] acc_mag;
	logic [ACC_W-1:0] div_in;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;
	logic [DATA_W-1:0] sat_res;

	assign acc_mag = acc_q[0][ACC_W-1] ? ACC_W'(-acc_q[0]) : ACC_W'(acc_q[0]);
	assign div_in  = acc_mag + ACC_W'(DIV_ROUND);

	lbs4_div255 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DSTART),
		.dividend (div_in),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Restore the sign and clamp to the signed 32-bit range.
	always_comb begin
		if (neg_q) begin
			if (div_quo > DIV_W'(64'h0000_0000_8000_0000)) begin
				sat_res = 32'h8000_0000;
			end else begin
				sat_res = -div_quo[DATA_W-1:0];
			end
		end else begin
			if (div_quo > DIV_W'(64'h0000_0000_7FFF_FFFF)) begin
				sat_res = 32'h7FFF_FFFF;
			end else begin
				sat_res = div_quo[DATA_W-1:0];
			end
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bone_q      <= '0;
			row_q       <= '0;
			step_q      <= '0;
			coord_q     <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_accept && func == FUNC_SKIN) begin
						bone_q  <= '0;
						row_q   <= '0;
						coord_q <= '0;
						err_q   <= slot_bad;
						state_q <= slot_bad ? S_DONE : S_FETCH;
					end
				end
				S_FETCH: begin
					step_q  <= STEP_X;
					state_q <= S_MUL;
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_Z) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					state_q <= S_WGT;
				end
				S_WGT: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (row_q == 2'(ROWS_PER_BONE - 1)) begin
						row_q <= '0;
						if (bone_q == 2'(BONES - 1)) begin
							state_q <= S_DSTART;
						end else begin
							bone_q  <= bone_q + 1'b1;
							state_q <= S_FETCH;
						end
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_FETCH;
					end
				end
				S_DSTART: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						coord_q <= coord_q + 1'b1;
						state_q <= (coord_q == 2'd2) ? S_DONE : S_DSTART;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers. The three accumulators rotate so that the one for
	// the current row, or the coordinate being divided, always sits in slot 0.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_accept && func == FUNC_SKIN) begin
			px_q     <= pos_x;
			py_q     <= pos_y;
			pz_q     <= pos_z;
			idx_q    <= bone_indices;
			wts_q    <= bone_weights;
			base_q   <= palette_base;
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
		end

		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
			if (step_q == STEP_X) begin
				sum_q <= SUM_W'($signed(pal_row[3]));
			end else begin
				sum_q <= sum_q + prod_floor;
			end
		end

		if (state_q == S_SUM) begin
			sum_q <= sum_q + prod_floor;
		end

		if (state_q == S_WGT) begin
			wprod_q <= WP_W'(sum_q) * WP_W'($signed({1'b0, cur_wt}));
		end

		if (state_q == S_ACC) begin
			acc_q[0] <= acc_q[1];
			acc_q[1] <= acc_q[2];
			acc_q[2] <= acc_q[0] + ACC_W'(wprod_q);
		end

		if (state_q == S_DSTART) begin
			neg_q    <= acc_q[0][ACC_W-1];
			acc_q[0] <= acc_q[1];
			acc_q[1] <= acc_q[2];
			acc_q[2] <= acc_q[0];
		end

		if (state_q == S_DWAIT && div_done) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
			res_q[2] <= sat_res;
		end

		if (state_q == S_DONE && out_free) begin
			skin_x_q     <= err_q ? '0 : res_q[0];
			skin_y_q     <= err_q ? '0 : res_q[1];
			skin_z_q     <= err_q ? '0 : res_q[2];
			slot_error_q <= err_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign skin_x     = $signed(skin_x_q);
	assign skin_y     = $signed(skin_y_q);
	assign skin_z     = $signed(skin_z_q);
	assign slot_error = slot_error_q;

endmodule

`default_nettype wire

### hw/rtl/lbs4_palette.sv
// Bone palette store: four column memories, one word written and one row read per cycle.
`default_nettype none

module lbs4_palette
	import lbs4_pkg::*;
#(
	parameter int ROWS = DEFAULT_BONE_SLOTS * ROWS_PER_BONE,
	localparam int RA = $clog2(ROWS)
) (
	input  wire                               clk,
	input  wire                               wr_en,
	input  wire  [1:0]                        wr_col,
	input  wire  [RA-1:0]                     wr_row,
	input  wire  [DATA_W-1:0]                 wr_data,
	input  wire                               rd_en,
	input  wire  [RA-1:0]                     rd_row,
	output logic [PAL_COLS-1:0][DATA_W-1:0]   rd_data
);

	// Each column of the 3x4 matrices lives in its own memory so that a whole
	// row comes out in one read.
	for (genvar c = 0; c < PAL_COLS; c++) begin : g_col
		logic [DATA_W-1:0] mem [0:ROWS-1];

		always_ff @(posedge clk) begin
			if (wr_en && (wr_col == 2'(c))) begin
				mem[wr_row] <= wr_data;
			end
			if (rd_en) begin
				rd_data[c] <= mem[rd_row];
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/lbs4_div255.sv
// Byte-serial divider by 255 for the blended coordinate magnitudes.
`default_nettype none

module lbs4_div255
	import lbs4_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire  [ACC_W-1:0]   dividend,
	output logic               done,
	output logic [DIV_W-1:0]   quotient
);

	logic [DIV_W-1:0] num_q;
	logic [DIV_W-1:0] quo_q;
	logic [7:0]       rem_q;
	logic [$clog2(DIV_BYTES)-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [15:0] part;
	logic [7:0]  dig_est;
	logic [8:0]  rem_est;
	logic [7:0]  dig;
	logic [7:0]  rem_nxt;

	// One long-division step in base 256. The estimate v/256 is at most one
	// short of v/255, so a single compare and subtract corrects it.
	always_comb begin
		part    = {rem_q, num_q[DIV_W-1 -: 8]};
		dig_est = part[15:8];
		rem_est = 9'(part[7:0]) + 9'(dig_est);
		if (rem_est >= 9'(DIVISOR)) begin
			dig     = dig_est + 8'd1;
			rem_nxt = 8'(rem_est - 9'(DIVISOR));
		end else begin
			dig     = dig_est;
			rem_nxt = rem_est[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(DIV_BYTES))'(DIV_BYTES - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= DIV_W'(dividend);
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[DIV_W-9:0], 8'h00};
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DIV_W-9:0], dig};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire
